// ----- rtl/core/srrb_pkg.sv -----
// Shared widths, codes, state type and control/status bundles for the stereo ring buffer.
package srrb_pkg;

  // Default sizes for the top-level parameters
  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BLOCK_DEF = 64;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int RATIO_W    = 20;
  localparam int FRAC_W     = 16;
  localparam int NUM_W      = 7;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int AVAIL_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Read position: frame index times step ratio, Q.FRAC_W
  localparam int POS_W  = NUM_W + RATIO_W;
  localparam int CONS_W = POS_W - FRAC_W;

  localparam int FRAC_MASK = (1 << FRAC_W) - 1;
  localparam int HALF_LSB  = 1 << (FRAC_W - 1);

  // Register reset values
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(1 << FRAC_W);
  localparam logic [NUM_W-1:0]   ROOM_RESET  = NUM_W'(64);

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ROOM  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOM       = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_CLEAR,
    S_PROD,
    S_CHECK,
    S_RADDR,
    S_RMUL,
    S_ROUT,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic sweep;      // zero one store entry, reset pointers
    logic latch;      // capture the accepted beat
    logic do_write;   // store one frame
    logic calc_prod;  // N times step ratio
    logic check;      // refusal checks, start read walk
    logic rd_mul;     // interpolation multiply
    logic emit;       // load one frame into output register
    logic load_resp;  // load a frameless result
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              sweep_done;
    logic              out_free;
    logic              chk_go;
    logic              emit_last;
  } stat_t;

endpackage

// ----- rtl/core/srrb_req_if.sv -----
// Request channel: valid/ready handshake with one command beat.
interface srrb_req_if;
  logic                                valid;
  logic                                ready;
  logic [srrb_pkg::FUNC_W-1:0]         func;
  logic signed [srrb_pkg::SAMPLE_W-1:0] left_in;
  logic signed [srrb_pkg::SAMPLE_W-1:0] right_in;
  logic [srrb_pkg::NUM_W-1:0]          num_frames;

  modport source (output valid, output func, output left_in, output right_in,
                  output num_frames, input ready);
  modport sink   (input valid, input func, input left_in, input right_in,
                  input num_frames, output ready);
endinterface

// ----- rtl/core/srrb_rsp_if.sv -----
// Result channel: valid/ready handshake with one result beat.
interface srrb_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srrb_pkg::SAMPLE_W-1:0] left_out;
  logic signed [srrb_pkg::SAMPLE_W-1:0] right_out;
  logic                                 sample_valid;
  logic [srrb_pkg::STATUS_W-1:0]        status;
  logic [srrb_pkg::CONS_W-1:0]          frames_consumed;
  logic [srrb_pkg::AVAIL_W-1:0]         frames_available;
  logic                                 last;

  modport source (output valid, output left_out, output right_out, output sample_valid,
                  output status, output frames_consumed, output frames_available,
                  output last, input ready);
  modport sink   (input valid, input left_out, input right_out, input sample_valid,
                  input status, input frames_consumed, input frames_available,
                  input last, output ready);
endinterface

// ----- rtl/core/srrb_ctrl.sv -----
// Sequencer for the ring buffer: walks each command through the datapath steps.
module srrb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output srrb_pkg::ctl_t  ctl,
  input  srrb_pkg::stat_t st
);

  srrb_pkg::state_t state;
  srrb_pkg::state_t state_next;

  // State register; reset starts the store zeroing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srrb_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      srrb_pkg::S_INIT: begin
        ctl.sweep = 1'b1;
        if (st.sweep_done) state_next = srrb_pkg::S_IDLE;
      end
      srrb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = srrb_pkg::S_DECODE;
        end
      end
      srrb_pkg::S_DECODE: begin
        unique case (st.func)
          srrb_pkg::FUNC_WRITE: state_next = srrb_pkg::S_WRITE;
          srrb_pkg::FUNC_READ:  state_next = srrb_pkg::S_PROD;
          srrb_pkg::FUNC_CLEAR: state_next = srrb_pkg::S_CLEAR;
          default:              state_next = srrb_pkg::S_RESP;
        endcase
      end
      srrb_pkg::S_WRITE: begin
        ctl.do_write = 1'b1;
        state_next   = srrb_pkg::S_RESP;
      end
      srrb_pkg::S_CLEAR: begin
        ctl.sweep = 1'b1;
        if (st.sweep_done) state_next = srrb_pkg::S_RESP;
      end
      srrb_pkg::S_PROD: begin
        ctl.calc_prod = 1'b1;
        state_next    = srrb_pkg::S_CHECK;
      end
      srrb_pkg::S_CHECK: begin
        ctl.check  = 1'b1;
        state_next = st.chk_go ? srrb_pkg::S_RADDR : srrb_pkg::S_RESP;
      end
      // store read issued from the current position
      srrb_pkg::S_RADDR: begin
        state_next = srrb_pkg::S_RMUL;
      end
      srrb_pkg::S_RMUL: begin
        ctl.rd_mul = 1'b1;
        state_next = srrb_pkg::S_ROUT;
      end
      srrb_pkg::S_ROUT: begin
        if (st.out_free) begin
          ctl.emit   = 1'b1;
          state_next = st.emit_last ? srrb_pkg::S_IDLE : srrb_pkg::S_RADDR;
        end
      end
      srrb_pkg::S_RESP: begin
        if (st.out_free) begin
          ctl.load_resp = 1'b1;
          state_next    = srrb_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/srrb_dp.sv -----
// Ring buffer datapath: frame store, pointers, config registers, interpolator, output register.
module srrb_dp #(
  parameter int DEPTH     = srrb_pkg::DEPTH_DEF,
  parameter int MAX_BLOCK = srrb_pkg::MAX_BLOCK_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srrb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [srrb_pkg::FUNC_W-1:0]          func,
  input  logic signed [srrb_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [srrb_pkg::SAMPLE_W-1:0] right_in,
  input  logic [srrb_pkg::NUM_W-1:0]           num_frames,
  output logic signed [srrb_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [srrb_pkg::SAMPLE_W-1:0] right_out,
  output logic                                 sample_valid,
  output logic [srrb_pkg::STATUS_W-1:0]        status,
  output logic [srrb_pkg::CONS_W-1:0]          frames_consumed,
  output logic [srrb_pkg::AVAIL_W-1:0]         frames_available,
  output logic                                 last,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  input  srrb_pkg::ctl_t                       ctl,
  output srrb_pkg::stat_t                      st
);

  localparam int SW   = srrb_pkg::SAMPLE_W;
  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int KW   = srrb_pkg::CONS_W;
  localparam int AW   = ((PW > KW) ? PW : KW) + 1;
  localparam int CMPW = (CW > KW) ? CW : KW;
  localparam int PRW  = srrb_pkg::FRAC_W + SW + 2;

  // Configuration registers
  logic [srrb_pkg::RATIO_W-1:0] step_ratio;
  logic                         overwrite_mode;
  logic [srrb_pkg::NUM_W-1:0]   output_room;

  // Latched command beat
  logic [srrb_pkg::FUNC_W-1:0] func_q;
  logic signed [SW-1:0]        left_q;
  logic signed [SW-1:0]        right_q;
  logic [srrb_pkg::NUM_W-1:0]  n_q;

  // Ring state
  logic [PW-1:0] rp;
  logic [PW-1:0] wp;
  logic [CW-1:0] count;
  logic [PW-1:0] sweep_addr;

  // Frame store
  logic [2*SW-1:0] mem [DEPTH];
  logic            mem_we;
  logic [PW-1:0]   mem_waddr;
  logic [2*SW-1:0] mem_wdata;
  logic [PW-1:0]   addr_a;
  logic [PW-1:0]   addr_b;
  logic [2*SW-1:0] rd_a;
  logic [2*SW-1:0] rd_b;

  // Read request state
  logic [srrb_pkg::POS_W-1:0]    prod;
  logic [srrb_pkg::POS_W-1:0]    cons_sum;
  logic [KW-1:0]                 cons_calc;
  logic [KW-1:0]                 cons;
  logic [srrb_pkg::POS_W-1:0]    pos;
  logic [srrb_pkg::NUM_W-1:0]    idx;
  logic [srrb_pkg::NUM_W-1:0]    room;
  logic [srrb_pkg::STATUS_W-1:0] res_status;
  logic                          short_data;
  logic                          over_room;
  logic                          emit_last;

  // Interpolator
  logic signed [SW-1:0]  a_l;
  logic signed [SW-1:0]  a_r;
  logic signed [SW:0]    diff_l;
  logic signed [SW:0]    diff_r;
  logic signed [PRW-1:0] mul_l;
  logic signed [PRW-1:0] mul_r;
  logic signed [PRW-1:0] t_l;
  logic signed [PRW-1:0] t_r;
  logic signed [PRW-1:0] sh_l;
  logic signed [PRW-1:0] sh_r;
  logic signed [SW-1:0]  val_l;
  logic signed [SW-1:0]  val_r;

  logic full;
  logic drop;
  logic [PW-1:0] wp_inc;
  logic [PW-1:0] rp_inc;
  logic [PW-1:0] rp_cons;
  logic [KW-1:0] k;

  // Modulo-DEPTH wrap for a sum known to be below twice DEPTH
  function automatic logic [PW-1:0] wrap(input logic [AW-1:0] s);
    logic [AW-1:0] d;
    d = s - AW'(DEPTH);
    return (s >= AW'(DEPTH)) ? d[PW-1:0] : s[PW-1:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio     <= srrb_pkg::RATIO_RESET;
      overwrite_mode <= 1'b0;
      output_room    <= srrb_pkg::ROOM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srrb_pkg::CFG_STEP_RATIO: step_ratio     <= cfg_data[srrb_pkg::RATIO_W-1:0];
        srrb_pkg::CFG_OVERWRITE:  overwrite_mode <= cfg_data[0];
        srrb_pkg::CFG_ROOM:       output_room    <= cfg_data[srrb_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      func_q  <= func;
      left_q  <= left_in;
      right_q <= right_in;
      n_q     <= num_frames;
    end
  end

  // Pointer arithmetic
  assign full   = (count == CW'(DEPTH));
  assign drop   = full && !overwrite_mode;
  assign wp_inc = (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_inc = (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
  assign k      = pos[srrb_pkg::POS_W-1:srrb_pkg::FRAC_W];
  assign addr_a = wrap(AW'(rp) + AW'(k));
  assign addr_b = wrap(AW'(rp) + AW'(k) + AW'(1));
  assign rp_cons = wrap(AW'(rp) + AW'(cons));

  // Zeroing sweep address, wraps back to zero at the end of each pass
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctl.sweep) begin
      sweep_addr <= (sweep_addr == PW'(DEPTH - 1)) ? '0 : sweep_addr + 1'b1;
    end
  end

  // Ring pointers and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.sweep) begin
      rp    <= '0;
      wp    <= '0;
      count <= '0;
    end else if (ctl.do_write && !drop) begin
      wp <= wp_inc;
      if (full) rp <= rp_inc;
      else      count <= count + 1'b1;
    end else if (ctl.emit && emit_last) begin
      rp    <= rp_cons;
      count <= count - CW'(cons);
    end
  end

  // Store write port: sweep zeros or a new frame
  assign mem_we    = ctl.sweep || (ctl.do_write && !drop);
  assign mem_waddr = ctl.sweep ? sweep_addr : wp;
  assign mem_wdata = ctl.sweep ? '0 : {left_q, right_q};

  // Store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Consumption ceil(N * ratio) and refusal checks
  assign cons_sum   = prod + srrb_pkg::POS_W'(srrb_pkg::FRAC_MASK);
  assign cons_calc  = cons_sum[srrb_pkg::POS_W-1:srrb_pkg::FRAC_W];
  assign room       = (output_room > srrb_pkg::NUM_W'(MAX_BLOCK)) ?
                      srrb_pkg::NUM_W'(MAX_BLOCK) : output_room;
  assign short_data = CMPW'(cons_calc) > CMPW'(count);
  assign over_room  = n_q > room;
  assign emit_last  = (idx + srrb_pkg::NUM_W'(1)) == n_q;

  // Read walk and result status
  always_ff @(posedge clk) begin
    if (ctl.calc_prod) begin
      prod <= {{srrb_pkg::RATIO_W{1'b0}}, n_q} * {{srrb_pkg::NUM_W{1'b0}}, step_ratio};
    end
    if (ctl.latch) begin
      res_status <= srrb_pkg::ST_OK;
    end else if (ctl.do_write) begin
      res_status <= drop ? srrb_pkg::ST_FULL : srrb_pkg::ST_OK;
    end else if (ctl.check) begin
      res_status <= short_data ? srrb_pkg::ST_SHORT :
                    over_room  ? srrb_pkg::ST_ROOM  : srrb_pkg::ST_OK;
    end
    if (ctl.check) begin
      cons <= cons_calc;
      pos  <= '0;
      idx  <= '0;
    end else if (ctl.emit) begin
      pos <= pos + srrb_pkg::POS_W'(step_ratio);
      idx <= idx + 1'b1;
    end
  end

  // Interpolation: a + floor((f * (b - a) + half) / 2^FRAC_W)
  assign diff_r = $signed({rd_b[SW-1], rd_b[SW-1:0]}) - $signed({rd_a[SW-1], rd_a[SW-1:0]});
  assign diff_l = $signed({rd_b[2*SW-1], rd_b[2*SW-1:SW]})
                - $signed({rd_a[2*SW-1], rd_a[2*SW-1:SW]});

  always_ff @(posedge clk) begin
    if (ctl.rd_mul) begin
      a_l   <= rd_a[2*SW-1:SW];
      a_r   <= rd_a[SW-1:0];
      mul_l <= $signed({1'b0, pos[srrb_pkg::FRAC_W-1:0]}) * diff_l;
      mul_r <= $signed({1'b0, pos[srrb_pkg::FRAC_W-1:0]}) * diff_r;
    end
  end

  assign t_l   = mul_l + $signed(PRW'(srrb_pkg::HALF_LSB));
  assign t_r   = mul_r + $signed(PRW'(srrb_pkg::HALF_LSB));
  assign sh_l  = t_l >>> srrb_pkg::FRAC_W;
  assign sh_r  = t_r >>> srrb_pkg::FRAC_W;
  assign val_l = a_l + sh_l[SW-1:0];
  assign val_r = a_r + sh_r[SW-1:0];

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit || ctl.load_resp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      left_out         <= val_l;
      right_out        <= val_r;
      sample_valid     <= 1'b1;
      status           <= srrb_pkg::ST_OK;
      frames_consumed  <= emit_last ? cons : '0;
      frames_available <= srrb_pkg::AVAIL_W'(emit_last ? count - CW'(cons) : count);
      last             <= emit_last;
    end else if (ctl.load_resp) begin
      left_out         <= '0;
      right_out        <= '0;
      sample_valid     <= 1'b0;
      status           <= res_status;
      frames_consumed  <= '0;
      frames_available <= srrb_pkg::AVAIL_W'(count);
      last             <= 1'b1;
    end
  end

  // Status to controller
  assign st.func       = func_q;
  assign st.sweep_done = (sweep_addr == PW'(DEPTH - 1));
  assign st.out_free   = !rsp_valid || rsp_ready;
  assign st.chk_go     = !short_data && !over_room && (n_q != '0);
  assign st.emit_last  = emit_last;

  // Fill count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  // An emitted frame lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> rsp_valid && sample_valid)
    else $error("emitted frame not presented");

  // Only the final frame of a read moves the head and the count
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    ctl.emit && !emit_last |=> $stable(rp) && $stable(count))
    else $error("ring state moved mid read");

  // A finished sweep leaves an empty ring
  a_sweep_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.sweep && st.sweep_done |=> count == '0 && rp == '0 && wp == '0)
    else $error("ring not empty after sweep");

endmodule

// ----- rtl/core/stereo_resampling_ring_buffer.sv -----
// Top level of the stereo resampling ring buffer.
//
//  port  | role   | beat
//  ------+--------+---------------------------------------------------------
//  req   | in     | func, left_in, right_in, num_frames
//  rsp   | out    | left_out, right_out, sample_valid, status,
//        |        | frames_consumed, frames_available, last
//  cfg   | write  | cfg_we, cfg_index, cfg_data (no read-back)
//
// Write: decode, store write, result load; unused command: decode, result load; clear: decode,
// zeroing sweep over all DEPTH entries, result load. Read of N frames: setup (decode, N * ratio
// multiply, checks), then per frame a store read, interpolation multiply and output load; a
// refused or empty read goes from the checks to the result state, which loads its one result.
// After reset a zeroing pass over the store runs before req.ready rises.
// A stalled rsp holds its beat in the output register and pauses the sequencer; the next
// req beat is taken in idle, in the cycle after a load at the earliest, while that result waits.
module stereo_resampling_ring_buffer #(
  parameter int DEPTH     = srrb_pkg::DEPTH_DEF,
  parameter int MAX_BLOCK = srrb_pkg::MAX_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srrb_pkg::CFG_DATA_W-1:0] cfg_data,
  srrb_req_if.sink                        req,
  srrb_rsp_if.source                      rsp
);

  srrb_pkg::ctl_t  ctl;
  srrb_pkg::stat_t st;

  // Sequencer
  srrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .ctl      (ctl),
    .st       (st)
  );

  // Store, pointers and interpolator
  srrb_dp #(
    .DEPTH     (DEPTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (req.func),
    .left_in          (req.left_in),
    .right_in         (req.right_in),
    .num_frames       (req.num_frames),
    .left_out         (rsp.left_out),
    .right_out        (rsp.right_out),
    .sample_valid     (rsp.sample_valid),
    .status           (rsp.status),
    .frames_consumed  (rsp.frames_consumed),
    .frames_available (rsp.frames_available),
    .last             (rsp.last),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .ctl              (ctl),
    .st               (st)
  );

endmodule
